// ----- rtl/aesm_pkg.sv -----
// Shared types, codes, S-box tables and column mixing for the AES block cipher.
// No dependencies; every other file imports this package.
`timescale 1ns / 1ps
`default_nettype none

package aesm_pkg;

    // Round key memory shape
    localparam int unsigned KEY_ROWS  = 15;
    localparam int unsigned ROW_W     = 128;
    localparam int unsigned KADDR_W   = $clog2(KEY_ROWS);

    // Key length codes
    localparam logic [1:0] KLEN_128 = 2'd0;
    localparam logic [1:0] KLEN_192 = 2'd1;
    localparam logic [1:0] KLEN_256 = 2'd2;

    // Cipher mode codes
    localparam logic [2:0] MODE_ECB_ENC = 3'd0;
    localparam logic [2:0] MODE_ECB_DEC = 3'd1;
    localparam logic [2:0] MODE_CBC_ENC = 3'd2;
    localparam logic [2:0] MODE_CBC_DEC = 3'd3;
    localparam logic [2:0] MODE_OFB     = 3'd4;

    // Configuration register indexes
    localparam logic [2:0] CFG_KEY_LENGTH  = 3'd0;
    localparam logic [2:0] CFG_CIPHER_MODE = 3'd1;
    localparam logic [2:0] CFG_KEY_WORD_0  = 3'd2;
    localparam logic [2:0] CFG_KEY_WORD_1  = 3'd3;
    localparam logic [2:0] CFG_KEY_WORD_2  = 3'd4;
    localparam logic [2:0] CFG_KEY_WORD_3  = 3'd5;

    typedef struct packed {
        logic [63:0] block_high;
        logic [63:0] block_low;
        logic [4:0]  valid_bytes;
        logic        start_of_message;
    } t_in;

    typedef struct packed {
        logic [63:0] result_high;
        logic [63:0] result_low;
    } t_out;

    // Write beat from key expansion into the round key memory
    typedef struct packed {
        logic               we;
        logic [KADDR_W-1:0] addr;
        logic [ROW_W-1:0]   data;
    } t_key_wr;

    // Operation of the shared round unit
    typedef struct packed {
        logic add_only;
        logic decrypt;
        logic mix;
    } t_rnd_ctl;

    // Forward S-box, entry 0 in the top byte
    localparam logic [2047:0] FWD_SBOX = {
        128'h637c777bf26b6fc53001672bfed7ab76,
        128'hca82c97dfa5947f0add4a2af9ca472c0,
        128'hb7fd9326363ff7cc34a5e5f171d83115,
        128'h04c723c31896059a071280e2eb27b275,
        128'h09832c1a1b6e5aa0523bd6b329e32f84,
        128'h53d100ed20fcb15b6acbbe394a4c58cf,
        128'hd0efaafb434d338545f9027f503c9fa8,
        128'h51a3408f929d38f5bcb6da2110fff3d2,
        128'hcd0c13ec5f974417c4a77e3d645d1973,
        128'h60814fdc222a908846eeb814de5e0bdb,
        128'he0323a0a4906245cc2d3ac629195e479,
        128'he7c8376d8dd54ea96c56f4ea657aae08,
        128'hba78252e1ca6b4c6e8dd741f4bbd8b8a,
        128'h703eb5664803f60e613557b986c11d9e,
        128'he1f8981169d98e949b1e87e9ce5528df,
        128'h8ca1890dbfe6426841992d0fb054bb16
    };

    // Invert the forward table at elaboration
    function automatic logic [2047:0] build_inv();
        logic [2047:0] inv;
        logic [7:0]    x8;
        logic [7:0]    s;
        inv = '0;
        for (int x = 0; x < 256; x++) begin
            x8 = 8'(x);
            s  = FWD_SBOX[{~x8, 3'b000} +: 8];
            inv[{~s, 3'b000} +: 8] = x8;
        end
        return inv;
    endfunction

    localparam logic [2047:0] INV_SUB = build_inv();

    function automatic logic [7:0] sbox(input logic [7:0] x);
        return FWD_SBOX[{~x, 3'b000} +: 8];
    endfunction

    function automatic logic [7:0] inv_sub(input logic [7:0] x);
        return INV_SUB[{~x, 3'b000} +: 8];
    endfunction

    function automatic logic [7:0] xtime(input logic [7:0] a);
        return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
    endfunction

    // Forward column mix, byte 0 in the top bits
    function automatic logic [31:0] mix_col(input logic [31:0] c);
        logic [7:0] a0, a1, a2, a3;
        a0 = c[31:24];
        a1 = c[23:16];
        a2 = c[15:8];
        a3 = c[7:0];
        return {xtime(a0) ^ xtime(a1) ^ a1 ^ a2 ^ a3,
                a0 ^ xtime(a1) ^ xtime(a2) ^ a2 ^ a3,
                a0 ^ a1 ^ xtime(a2) ^ xtime(a3) ^ a3,
                xtime(a0) ^ a0 ^ a1 ^ a2 ^ xtime(a3)};
    endfunction

    // Inverse column mix
    function automatic logic [31:0] inv_mix_col(input logic [31:0] c);
        logic [7:0] a [4];
        logic [7:0] m2 [4];
        logic [7:0] m4 [4];
        logic [7:0] m8 [4];
        logic [7:0] m9 [4];
        logic [7:0] mb [4];
        logic [7:0] md [4];
        logic [7:0] me [4];
        for (int i = 0; i < 4; i++) begin
            a[i]  = c[31-8*i -: 8];
            m2[i] = xtime(a[i]);
            m4[i] = xtime(m2[i]);
            m8[i] = xtime(m4[i]);
            m9[i] = m8[i] ^ a[i];
            mb[i] = m8[i] ^ m2[i] ^ a[i];
            md[i] = m8[i] ^ m4[i] ^ a[i];
            me[i] = m8[i] ^ m4[i] ^ m2[i];
        end
        return {me[0] ^ mb[1] ^ md[2] ^ m9[3],
                m9[0] ^ me[1] ^ mb[2] ^ md[3],
                md[0] ^ m9[1] ^ me[2] ^ mb[3],
                mb[0] ^ md[1] ^ m9[2] ^ me[3]};
    endfunction

endpackage

`default_nettype wire

// ----- rtl/aes_block_cipher_with_modes.sv -----
// AES block cipher with ECB, CBC and OFB chaining; top level and sequencer.
// Depends on aesm_pkg, aesm_key_exp, aesm_rkey_mem and aesm_round.
//
// One block is worked at a time. An item goes from acceptance to the result
// register through the first round key read, Nr + 1 passes through the single
// round unit, and the forming of the chained result. The round key memory has
// a registered read, so the first round key is read ahead of the first pass.
// After a write to the key registers or the key length, the next block first
// expands the keys, writing one schedule word per cycle, before that read.
// Input is taken again as soon as a result sits in the output register.
`timescale 1ns / 1ps
`default_nettype none

module aes_block_cipher_with_modes (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_in_valid,
    output logic                o_in_ready,
    input  wire aesm_pkg::t_in  i_in_data,
    output logic                o_out_valid,
    input  wire logic           i_out_ready,
    output aesm_pkg::t_out      o_out_data,
    input  wire logic           i_cfg_we,
    input  wire logic [2:0]     i_cfg_index,
    input  wire logic [63:0]    i_cfg_data
);
    import aesm_pkg::*;

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_EXPAND = 3'd1;
    localparam logic [2:0] ST_LOAD   = 3'd2;
    localparam logic [2:0] ST_RUN    = 3'd3;
    localparam logic [2:0] ST_HOLD   = 3'd4;

    logic [2:0]         r_fsm;
    logic [1:0]         r_klen;
    logic [2:0]         r_mode;
    logic [63:0]        r_key [4];
    logic               r_keys_ready;
    logic [127:0]       r_state;
    logic [127:0]       r_blk;
    logic [127:0]       r_chain;
    logic [3:0]         r_step;
    logic [KADDR_W-1:0] r_kaddr;
    logic               r_out_valid;
    t_out               r_out;

    logic               accept;
    logic               dec;
    logic [3:0]         nr;
    logic [127:0]       raw;
    logic [127:0]       blk;
    logic [127:0]       cv;
    logic [127:0]       rkey;
    logic [127:0]       rnd_out;
    logic [127:0]       res;
    logic [127:0]       n_chain;
    logic               emit;
    logic               kx_done;
    t_key_wr            kx_wr;
    t_rnd_ctl           ctl;

    assign accept      = i_in_valid && o_in_ready;
    assign o_in_ready  = (r_fsm == ST_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;
    assign dec         = (r_mode == MODE_ECB_DEC) || (r_mode == MODE_CBC_DEC);
    assign emit        = (r_fsm == ST_HOLD) && (!r_out_valid || i_out_ready);

    always_comb begin
        case (r_klen)
            KLEN_128: nr = 4'd10;
            KLEN_192: nr = 4'd12;
            default:  nr = 4'd14;
        endcase
    end

    // Zero the bytes past the valid count
    always_comb begin
        raw = {i_in_data.block_high, i_in_data.block_low};
        for (int i = 0; i < 16; i++) begin
            if (5'(i) < i_in_data.valid_bytes) begin
                blk[127-8*i -: 8] = raw[127-8*i -: 8];
            end else begin
                blk[127-8*i -: 8] = 8'h00;
            end
        end
        cv = i_in_data.start_of_message ? '0 : r_chain;
    end

    // Round unit control
    always_comb begin
        ctl.add_only = (r_step == 4'd0);
        ctl.decrypt  = dec;
        ctl.mix      = (r_step != nr);
    end

    // Chained result
    always_comb begin
        res     = r_state;
        n_chain = r_chain;
        case (r_mode)
            MODE_ECB_ENC, MODE_ECB_DEC: begin
                res = r_state;
            end
            MODE_CBC_ENC: begin
                n_chain = r_state;
            end
            MODE_CBC_DEC: begin
                res     = r_state ^ r_chain;
                n_chain = r_blk;
            end
            default: begin
                res     = r_blk ^ r_state;
                n_chain = r_state;
            end
        endcase
    end

    aesm_key_exp u_key_exp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (accept && !r_keys_ready),
        .i_klen  (r_klen),
        .i_key   ({r_key[0], r_key[1], r_key[2], r_key[3]}),
        .o_wr    (kx_wr),
        .o_done  (kx_done)
    );

    aesm_rkey_mem u_rkey_mem (
        .i_clk   (i_clk),
        .i_wr    (kx_wr),
        .i_raddr (r_kaddr),
        .o_rdata (rkey)
    );

    aesm_round u_round (
        .i_state (r_state),
        .i_rkey  (rkey),
        .i_ctl   (ctl),
        .o_state (rnd_out)
    );

    // Configuration and key status
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_klen       <= KLEN_128;
            r_mode       <= MODE_ECB_ENC;
            r_keys_ready <= 1'b0;
            for (int i = 0; i < 4; i++) begin
                r_key[i] <= '0;
            end
        end else begin
            if (kx_done) begin
                r_keys_ready <= 1'b1;
            end
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_KEY_LENGTH: begin
                        r_klen       <= (i_cfg_data[1:0] == 2'd3) ? KLEN_256
                                                                  : i_cfg_data[1:0];
                        r_keys_ready <= 1'b0;
                    end
                    CFG_CIPHER_MODE: begin
                        r_mode <= (i_cfg_data[2:0] > MODE_OFB) ? MODE_OFB
                                                               : i_cfg_data[2:0];
                    end
                    CFG_KEY_WORD_0, CFG_KEY_WORD_1, CFG_KEY_WORD_2, CFG_KEY_WORD_3: begin
                        r_key[2'(i_cfg_index - CFG_KEY_WORD_0)] <= i_cfg_data;
                        r_keys_ready <= 1'b0;
                    end
                    default: begin
                    end
                endcase
            end
        end
    end

    // Sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fsm       <= ST_IDLE;
            r_chain     <= '0;
            r_step      <= '0;
            r_kaddr     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (r_out_valid && i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            case (r_fsm)
                ST_IDLE: begin
                    if (accept) begin
                        if (i_in_data.start_of_message) begin
                            r_chain <= '0;
                        end
                        r_kaddr <= dec ? KADDR_W'(nr) : '0;
                        r_fsm   <= r_keys_ready ? ST_LOAD : ST_EXPAND;
                    end
                end
                ST_EXPAND: begin
                    if (kx_done) begin
                        r_fsm <= ST_LOAD;
                    end
                end
                ST_LOAD: begin
                    r_step  <= '0;
                    r_kaddr <= dec ? r_kaddr - KADDR_W'(1) : r_kaddr + KADDR_W'(1);
                    r_fsm   <= ST_RUN;
                end
                ST_RUN: begin
                    if (!dec) begin
                        if (r_kaddr != KADDR_W'(nr)) begin
                            r_kaddr <= r_kaddr + KADDR_W'(1);
                        end
                    end else if (r_kaddr != '0) begin
                        r_kaddr <= r_kaddr - KADDR_W'(1);
                    end
                    r_step <= r_step + 4'd1;
                    if (r_step == nr) begin
                        r_fsm <= ST_HOLD;
                    end
                end
                ST_HOLD: begin
                    if (emit) begin
                        r_chain     <= n_chain;
                        r_out_valid <= 1'b1;
                        r_fsm       <= ST_IDLE;
                    end
                end
                default: begin
                    r_fsm <= ST_IDLE;
                end
            endcase
        end
    end

    // Datapath registers
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_blk <= blk;
            case (r_mode)
                MODE_CBC_ENC: r_state <= blk ^ cv;
                MODE_OFB:     r_state <= cv;
                default:      r_state <= blk;
            endcase
        end else if (r_fsm == ST_RUN) begin
            r_state <= rnd_out;
        end
        if (emit) begin
            r_out <= res;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/aesm_key_exp.sv -----
// Key expansion: produces one 32-bit schedule word per cycle and writes each
// completed 128-bit row into the round key memory. Depends on aesm_pkg.
`timescale 1ns / 1ps
`default_nettype none

module aesm_key_exp (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_start,
    input  wire logic [1:0]             i_klen,
    input  wire logic [255:0]           i_key,
    output aesm_pkg::t_key_wr           o_wr,
    output logic                        o_done
);
    import aesm_pkg::*;

    logic        r_busy;
    logic        r_done;
    logic [5:0]  r_idx;
    logic [2:0]  r_j;
    logic [7:0]  r_rc;
    logic [31:0] r_win [8];
    logic [95:0] r_row;

    logic [3:0]  nk;
    logic [5:0]  last_idx;
    logic [2:0]  back_sel;
    logic [31:0] prev;
    logic [31:0] t;
    logic [31:0] w;

    // Schedule shape for the key length
    always_comb begin
        case (i_klen)
            KLEN_128: begin nk = 4'd4; last_idx = 6'd43; end
            KLEN_192: begin nk = 4'd6; last_idx = 6'd51; end
            default:  begin nk = 4'd8; last_idx = 6'd59; end
        endcase
        back_sel = 3'(4'd8 - nk);
    end

    // Next schedule word
    always_comb begin
        prev = r_win[7];
        t    = prev;
        if (r_j == 3'd0) begin
            t = {sbox(prev[23:16]) ^ r_rc, sbox(prev[15:8]), sbox(prev[7:0]),
                 sbox(prev[31:24])};
        end else if (nk == 4'd8 && r_j == 3'd4) begin
            t = {sbox(prev[31:24]), sbox(prev[23:16]), sbox(prev[15:8]),
                 sbox(prev[7:0])};
        end
        if (r_idx < 6'(nk)) begin
            w = i_key[{~r_idx[2:0], 5'b00000} +: 32];
        end else begin
            w = r_win[back_sel] ^ t;
        end
    end

    // Write a row once its fourth word is ready
    always_comb begin
        o_wr.we   = r_busy && (r_idx[1:0] == 2'b11);
        o_wr.addr = r_idx[5:2];
        o_wr.data = {r_row, w};
    end

    assign o_done = r_done;

    // Control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_idx  <= '0;
            r_j    <= '0;
            r_rc   <= 8'h01;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_idx  <= '0;
                r_j    <= '0;
                r_rc   <= 8'h01;
            end else if (r_busy) begin
                r_idx <= r_idx + 6'd1;
                r_j   <= (4'(r_j) == nk - 4'd1) ? 3'd0 : r_j + 3'd1;
                if (r_idx >= 6'(nk) && r_j == 3'd0) begin
                    r_rc <= xtime(r_rc);
                end
                if (r_idx == last_idx) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Word window and row collector
    always_ff @(posedge i_clk) begin
        if (r_busy) begin
            for (int i = 0; i < 7; i++) begin
                r_win[i] <= r_win[i+1];
            end
            r_win[7] <= w;
            r_row    <= {r_row[63:0], w};
        end
    end

endmodule

`default_nettype wire

// ----- rtl/aesm_rkey_mem.sv -----
// Round key memory: one write port, one read port, registered read data.
// Depends on aesm_pkg.
`timescale 1ns / 1ps
`default_nettype none

module aesm_rkey_mem (
    input  wire logic                          i_clk,
    input  wire aesm_pkg::t_key_wr             i_wr,
    input  wire logic [aesm_pkg::KADDR_W-1:0]  i_raddr,
    output logic [aesm_pkg::ROW_W-1:0]         o_rdata
);
    import aesm_pkg::*;

    logic [ROW_W-1:0] r_mem [KEY_ROWS];
    logic [ROW_W-1:0] r_rdata;

    // Write and read
    always_ff @(posedge i_clk) begin
        if (i_wr.we) begin
            r_mem[i_wr.addr] <= i_wr.data;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// ----- rtl/aesm_round.sv -----
// Shared round unit: key add alone, a forward round or an inverse round.
// Depends on aesm_pkg.
`timescale 1ns / 1ps
`default_nettype none

module aesm_round (
    input  wire logic [aesm_pkg::ROW_W-1:0] i_state,
    input  wire logic [aesm_pkg::ROW_W-1:0] i_rkey,
    input  wire aesm_pkg::t_rnd_ctl         i_ctl,
    output logic [aesm_pkg::ROW_W-1:0]      o_state
);
    import aesm_pkg::*;

    logic [7:0]       s [16];
    logic [7:0]       te [16];
    logic [7:0]       td [16];
    logic [127:0]     ve;
    logic [127:0]     vd;
    logic [127:0]     me;
    logic [127:0]     md;

    always_comb begin
        for (int i = 0; i < 16; i++) begin
            s[i] = i_state[127-8*i -: 8];
        end
        // Substitute and shift rows, both directions
        for (int c = 0; c < 4; c++) begin
            for (int q = 0; q < 4; q++) begin
                te[q+4*c] = sbox(s[q+4*((c+q)%4)]);
                td[q+4*((c+q)%4)] = inv_sub(s[q+4*c]);
            end
        end
        for (int i = 0; i < 16; i++) begin
            ve[127-8*i -: 8] = te[i];
            vd[127-8*i -: 8] = td[i];
        end
        vd = vd ^ i_rkey;
        // Mix columns
        for (int c = 0; c < 4; c++) begin
            me[127-32*c -: 32] = mix_col(ve[127-32*c -: 32]);
            md[127-32*c -: 32] = inv_mix_col(vd[127-32*c -: 32]);
        end
        if (i_ctl.add_only) begin
            o_state = i_state ^ i_rkey;
        end else if (i_ctl.decrypt) begin
            o_state = i_ctl.mix ? md : vd;
        end else begin
            o_state = (i_ctl.mix ? me : ve) ^ i_rkey;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/aesm_checker.sv -----
// Port-level checks for the AES block cipher top level, with its bind.
// Depends on aesm_pkg and aes_block_cipher_with_modes.
`timescale 1ns / 1ps
`default_nettype none

module aesm_checker (
    input wire logic           i_clk,
    input wire logic           i_rst_n,
    input wire logic           i_in_valid,
    input wire logic           o_in_ready,
    input wire logic           o_out_valid,
    input wire logic           i_out_ready,
    input wire aesm_pkg::t_out o_out_data
);
    import aesm_pkg::*;

    // Hold a stalled result beat
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_data))
        else $error("result beat dropped or changed while stalled");

    // One block at a time: no accept on the cycle after an accept
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> !o_in_ready)
        else $error("input taken while a block is in flight");

    // Lower bound on how soon a result may follow an accept into an empty output
    a_min_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready && !o_out_valid |=> ##1 !o_out_valid)
        else $error("result appeared too early");

    // Nothing shown straight out of reset
    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

endmodule

bind aes_block_cipher_with_modes aesm_checker u_aesm_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_ready  (o_in_ready),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out_data  (o_out_data)
);

`default_nettype wire

// ----- tb/sv/tb_aes_block_cipher_with_modes.sv -----
// Self-checking testbench for the AES block cipher with ECB, CBC and OFB chaining.
// Depends on aesm_pkg and aes_block_cipher_with_modes; holds its own cipher predictor.
`timescale 1ns / 1ps

module tb_aes_block_cipher_with_modes;
    import aesm_pkg::*;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_in_valid = 1'b0;
    logic        o_in_ready;
    t_in         i_in_data = '0;
    logic        o_out_valid;
    logic        i_out_ready = 1'b0;
    t_out        o_out_data;
    logic        i_cfg_we = 1'b0;
    logic [2:0]  i_cfg_index = '0;
    logic [63:0] i_cfg_data = '0;

    aes_block_cipher_with_modes uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always #5 i_clk = ~i_clk;

    // Shadow state of the cipher
    logic [7:0]   fwd_tab [256];
    logic [7:0]   inv_tab [256];
    logic [127:0] round_keys [15];
    logic [127:0] chain_blk;
    logic         schedule_ok;
    logic [1:0]   key_len;
    logic [2:0]   chain_mode;
    logic [63:0]  key_words [4];

    t_out   cipher_results [$];
    int     fail_count = 0;
    int     gap_max = 16;
    int     stall_max = 16;
    int     stall_left = 0;
    int     long_hold = 0;

    function automatic logic [7:0] gf_mul(logic [7:0] a, logic [7:0] b);
        logic [7:0] p;
        p = '0;
        for (int i = 0; i < 8; i++) begin
            if (b[0]) p ^= a;
            a = {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
            b = b >> 1;
        end
        return p;
    endfunction

    function automatic logic [7:0] rotl(logic [7:0] v, int n);
        return (v << n) | (v >> (8 - n));
    endfunction

    // Derive both substitution tables from the field inverse
    task automatic build_tables();
        logic [7:0] inv, pw, s;
        int e;
        for (int x = 0; x < 256; x++) begin
            inv = '0;
            if (x != 0) begin
                inv = 8'd1;
                pw = 8'(x);
                e = 254;
                while (e != 0) begin
                    if (e % 2 == 1) inv = gf_mul(inv, pw);
                    pw = gf_mul(pw, pw);
                    e = e / 2;
                end
            end
            s = inv ^ rotl(inv, 1) ^ rotl(inv, 2) ^ rotl(inv, 3) ^ rotl(inv, 4) ^ 8'h63;
            fwd_tab[x] = s;
            inv_tab[s] = 8'(x);
        end
    endtask

    function automatic int rounds_for_key();
        return key_len == KLEN_128 ? 10 : key_len == KLEN_192 ? 12 : 14;
    endfunction

    task automatic expand_schedule();
        logic [7:0] w [240];
        logic [7:0] t [4];
        logic [7:0] f, rc;
        int nk, kb, total;
        nk = key_len == KLEN_128 ? 4 : key_len == KLEN_192 ? 6 : 8;
        kb = 4 * nk;
        total = 16 * (rounds_for_key() + 1);
        rc = 8'd1;
        for (int i = 0; i < kb; i++) w[i] = key_words[i / 8][63 - 8 * (i % 8) -: 8];
        for (int c = kb; c < total; c += 4) begin
            for (int a = 0; a < 4; a++) t[a] = w[c - 4 + a];
            if (c % kb == 0) begin
                f = t[0];
                t[0] = fwd_tab[t[1]] ^ rc;
                t[1] = fwd_tab[t[2]];
                t[2] = fwd_tab[t[3]];
                t[3] = fwd_tab[f];
                rc = gf_mul(rc, 8'd2);
            end else if (nk == 8 && c % kb == 16) begin
                for (int a = 0; a < 4; a++) t[a] = fwd_tab[t[a]];
            end
            for (int a = 0; a < 4; a++) w[c + a] = w[c - kb + a] ^ t[a];
        end
        for (int r = 0; r * 16 < total; r++)
            for (int i = 0; i < 16; i++) round_keys[r][127 - 8 * i -: 8] = w[16 * r + i];
        schedule_ok = 1'b1;
    endtask

    function automatic logic [127:0] encrypt_blk(logic [127:0] s);
        logic [127:0] t;
        logic [7:0] a0, a1, a2, a3;
        int nr;
        nr = rounds_for_key();
        s ^= round_keys[0];
        for (int r = 1; r <= nr; r++) begin
            for (int c = 0; c < 4; c++)
                for (int q = 0; q < 4; q++)
                    t[127 - 8 * (q + 4 * c) -: 8] =
                        fwd_tab[s[127 - 8 * (q + 4 * ((c + q) % 4)) -: 8]];
            if (r != nr) begin
                for (int c = 0; c < 4; c++) begin
                    a0 = t[127 - 32 * c -: 8];
                    a1 = t[119 - 32 * c -: 8];
                    a2 = t[111 - 32 * c -: 8];
                    a3 = t[103 - 32 * c -: 8];
                    s[127 - 32 * c -: 8] = gf_mul(a0, 2) ^ gf_mul(a1, 3) ^ a2 ^ a3;
                    s[119 - 32 * c -: 8] = a0 ^ gf_mul(a1, 2) ^ gf_mul(a2, 3) ^ a3;
                    s[111 - 32 * c -: 8] = a0 ^ a1 ^ gf_mul(a2, 2) ^ gf_mul(a3, 3);
                    s[103 - 32 * c -: 8] = gf_mul(a0, 3) ^ a1 ^ a2 ^ gf_mul(a3, 2);
                end
            end else begin
                s = t;
            end
            s ^= round_keys[r];
        end
        return s;
    endfunction

    function automatic logic [127:0] decrypt_blk(logic [127:0] s);
        logic [127:0] t;
        logic [7:0] a0, a1, a2, a3;
        int nr;
        nr = rounds_for_key();
        s ^= round_keys[nr];
        for (int r = nr - 1; r >= 0; r--) begin
            for (int c = 0; c < 4; c++)
                for (int q = 0; q < 4; q++)
                    t[127 - 8 * (q + 4 * ((c + q) % 4)) -: 8] =
                        inv_tab[s[127 - 8 * (q + 4 * c) -: 8]];
            s = t ^ round_keys[r];
            if (r != 0) begin
                for (int c = 0; c < 4; c++) begin
                    a0 = s[127 - 32 * c -: 8];
                    a1 = s[119 - 32 * c -: 8];
                    a2 = s[111 - 32 * c -: 8];
                    a3 = s[103 - 32 * c -: 8];
                    s[127 - 32 * c -: 8] = gf_mul(a0, 14) ^ gf_mul(a1, 11) ^ gf_mul(a2, 13)
                                          ^ gf_mul(a3, 9);
                    s[119 - 32 * c -: 8] = gf_mul(a0, 9) ^ gf_mul(a1, 14) ^ gf_mul(a2, 11)
                                          ^ gf_mul(a3, 13);
                    s[111 - 32 * c -: 8] = gf_mul(a0, 13) ^ gf_mul(a1, 9) ^ gf_mul(a2, 14)
                                          ^ gf_mul(a3, 11);
                    s[103 - 32 * c -: 8] = gf_mul(a0, 11) ^ gf_mul(a1, 13) ^ gf_mul(a2, 9)
                                          ^ gf_mul(a3, 14);
                end
            end
        end
        return s;
    endfunction

    // Work out the result of one accepted block and advance the chain
    task automatic predict_cipher(t_in blk_in);
        logic [127:0] raw, blk, res;
        t_out r;
        if (!schedule_ok) expand_schedule();
        if (blk_in.start_of_message) chain_blk = '0;
        raw = {blk_in.block_high, blk_in.block_low};
        for (int i = 0; i < 16; i++)
            blk[127 - 8 * i -: 8] = (i < blk_in.valid_bytes) ? raw[127 - 8 * i -: 8] : 8'h00;
        case (chain_mode)
            MODE_ECB_ENC: res = encrypt_blk(blk);
            MODE_ECB_DEC: res = decrypt_blk(blk);
            MODE_CBC_ENC: begin
                res = encrypt_blk(blk ^ chain_blk);
                chain_blk = res;
            end
            MODE_CBC_DEC: begin
                res = decrypt_blk(blk) ^ chain_blk;
                chain_blk = blk;
            end
            default: begin
                chain_blk = encrypt_blk(chain_blk);
                res = blk ^ chain_blk;
            end
        endcase
        r.result_high = res[127:64];
        r.result_low = res[63:0];
        cipher_results.push_back(r);
    endtask

    task automatic write_reg(logic [2:0] idx, logic [63:0] val);
        @(negedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            CFG_KEY_LENGTH: begin
                key_len = (val[1:0] > KLEN_256) ? KLEN_256 : val[1:0];
                schedule_ok = 1'b0;
            end
            CFG_CIPHER_MODE: chain_mode = (val[2:0] > MODE_OFB) ? MODE_OFB : val[2:0];
            default: begin
                key_words[idx - CFG_KEY_WORD_0] = val;
                schedule_ok = 1'b0;
            end
        endcase
    endtask

    // Hold until every result is back, then let the sequencer settle
    task automatic wait_drained();
        while (cipher_results.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
    endtask

    task automatic set_key(logic [1:0] len, logic [63:0] k0, logic [63:0] k1,
                           logic [63:0] k2, logic [63:0] k3);
        write_reg(CFG_KEY_LENGTH, {62'd0, len});
        write_reg(CFG_KEY_WORD_0, k0);
        write_reg(CFG_KEY_WORD_1, k1);
        write_reg(CFG_KEY_WORD_2, k2);
        write_reg(CFG_KEY_WORD_3, k3);
    endtask

    task automatic send_block(logic [63:0] hi, logic [63:0] lo, logic [4:0] nvalid,
                              logic som);
        int gap;
        t_in it;
        gap = $urandom_range(0, gap_max);
        it.block_high = hi;
        it.block_low = lo;
        it.valid_bytes = nvalid;
        it.start_of_message = som;
        if (gap > 0) begin
            @(negedge i_clk);
            i_in_valid <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        i_in_valid <= 1'b1;
        i_in_data <= it;
        do @(posedge i_clk); while (!o_in_ready);
        predict_cipher(it);
    endtask

    task automatic release_input();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
    endtask

    function automatic logic [63:0] rand64();
        return {$urandom(), $urandom()};
    endfunction

    // Known-answer key, every mode code and the edges of the valid count
    task automatic test_directed();
        logic [4:0] counts [8];
        counts = '{5'd0, 5'd1, 5'd15, 5'd16, 5'd17, 5'd31, 5'd5, 5'd16};
        set_key(KLEN_128, 64'h0001020304050607, 64'h08090a0b0c0d0e0f, '0, '0);
        for (int m = 0; m < 8; m++) begin
            wait_drained();
            write_reg(CFG_CIPHER_MODE, 64'(m));
            send_block(64'h0011223344556677, 64'h8899aabbccddeeff, 5'd16, 1'b1);
            send_block('1, '1, counts[m], 1'b0);
            release_input();
        end
        wait_drained();
        set_key(KLEN_256 + 2'd1, '1, '1, '1, '1);
        write_reg(CFG_CIPHER_MODE, {61'd0, MODE_OFB});
        send_block('0, '0, 5'd16, 1'b1);
        send_block('1, '1, 5'd3, 1'b0);
        release_input();
    endtask

    // Messages of random content under changing keys, lengths and modes
    task automatic test_random_messages();
        logic [63:0] kw;
        for (int ph = 0; ph < 12; ph++) begin
            wait_drained();
            gap_max = (ph % 4 == 3) ? 0 : 16;
            stall_max = (ph % 4 == 3) ? 0 : 16;
            kw = (ph == 0) ? '0 : '1;
            if (ph < 2) set_key(2'(ph * 2), kw, kw, kw, kw);
            else set_key(2'($urandom_range(0, 3)), rand64(), rand64(), rand64(), rand64());
            write_reg(CFG_CIPHER_MODE, 64'($urandom_range(0, 7)));
            for (int n = 0; n < 90; n++)
                send_block(rand64(), rand64(),
                           ($urandom_range(0, 5) == 0) ? 5'($urandom_range(0, 31)) : 5'd16,
                           n == 0 || $urandom_range(0, 9) == 0);
            release_input();
        end
        gap_max = 16;
        stall_max = 16;
    endtask

    // Starve the output so the block fills and pushes back on its input
    task automatic test_output_hold();
        wait_drained();
        write_reg(CFG_CIPHER_MODE, {61'd0, MODE_CBC_DEC});
        gap_max = 0;
        long_hold = 400;
        for (int n = 0; n < 20; n++) send_block(rand64(), rand64(), 5'd16, n == 0);
        release_input();
        gap_max = 16;
    endtask

    // Drive the receiver's ready; stall lengths are chosen on each beat
    initial begin
        forever begin
            @(negedge i_clk);
            if (stall_left > 0) begin
                i_out_ready <= 1'b0;
                stall_left--;
            end else begin
                i_out_ready <= 1'b1;
            end
        end
    end

    // Compare each result beat with the oldest prediction
    always @(posedge i_clk) begin
        t_out exp_r;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (cipher_results.size() == 0) begin
                $error("unexpected result beat %h", o_out_data);
                fail_count++;
            end else begin
                exp_r = cipher_results.pop_front();
                if (o_out_data.result_high !== exp_r.result_high) begin
                    $error("result_high expected %h actual %h",
                           exp_r.result_high, o_out_data.result_high);
                    fail_count++;
                end
                if (o_out_data.result_low !== exp_r.result_low) begin
                    $error("result_low expected %h actual %h",
                           exp_r.result_low, o_out_data.result_low);
                    fail_count++;
                end
            end
            if (long_hold > 0) begin
                stall_left = long_hold;
                long_hold = 0;
            end else begin
                stall_left = $urandom_range(0, stall_max);
            end
        end
    end

    initial begin
        #20ms;
        $display("aes_block_cipher_with_modes: mismatch");
        $finish;
    end

    initial begin
        build_tables();
        key_len = KLEN_128;
        chain_mode = MODE_ECB_ENC;
        chain_blk = '0;
        schedule_ok = 1'b0;
        for (int i = 0; i < 4; i++) key_words[i] = '0;
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        test_directed();
        test_random_messages();
        test_output_hold();
        while (cipher_results.size() != 0) @(posedge i_clk);
        repeat (30) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("aes_block_cipher_with_modes: match");
        end else begin
            $display("aes_block_cipher_with_modes: mismatch");
        end
        $finish;
    end

endmodule

// ----- filelist.f -----
rtl/aesm_pkg.sv
rtl/aesm_key_exp.sv
rtl/aesm_rkey_mem.sv
rtl/aesm_round.sv
rtl/aes_block_cipher_with_modes.sv
rtl/aesm_checker.sv
tb/sv/tb_aes_block_cipher_with_modes.sv
